/* design/timeout_timer_table_top_macros.svh */
// Assertion macros for the timeout timer table.
// Used by timeout_timer_table_top; expects clk and arst_n in the including scope.
`ifndef TIMEOUT_TIMER_TABLE_TOP_MACROS_SVH
`define TIMEOUT_TIMER_TABLE_TOP_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define TTT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timeout timer table: same-cycle check failed");

// Whenever ante holds, cons must hold in the next cycle.
`define TTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timeout timer table: next-cycle check failed");

`endif

/* design/ttt_pkg.sv */
// Shared constants, types and helpers of the timeout timer table.
// No dependencies; imported by every module and interface of the block but ttt_ram.
package ttt_pkg;

	localparam int ENTRIES = 32;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int OP_W   = 2;
	localparam int IDX_W  = 5;
	localparam int DUR_W  = 31;
	localparam int NOW_W  = 48;
	localparam int IVL_W  = 32;
	localparam int WORD_W = DUR_W + NOW_W;

	localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

	localparam logic [IVL_W-1:0] CFG_RESET = 32'd60000;
	localparam logic [NOW_W:0]   MARGIN_MS = (NOW_W + 1)'(1000);

	// Read stage: the entry being read from the table.
	typedef struct packed {
		logic          occ;
		logic          ev;
		logic [AW-1:0] idx;
	} s1_t;

	// Evaluated stage: classification of one entry against the scan time.
	typedef struct packed {
		logic             occ;
		logic             exp;
		logic             pend;
		logic [AW-1:0]    idx;
		logic [NOW_W-1:0] rem;
	} s2_t;

	// Remaining time plus the margin, saturated to the interval width.
	function automatic logic [IVL_W-1:0] sat_interval(input logic [NOW_W-1:0] rem);
		logic [NOW_W:0] sum;
		sum = {1'b0, rem} + MARGIN_MS;
		if (sum[NOW_W:IVL_W] != '0) begin
			return '1;
		end
		return sum[IVL_W-1:0];
	endfunction

endpackage

/* design/ttt_in_if.sv */
// Input channel of the timeout timer table: valid/ready plus one command item.
// Depends on ttt_pkg for the field widths.
interface ttt_in_if import ttt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [IDX_W-1:0] entry_index;
	logic [DUR_W-1:0] timeout_ms;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, opcode, entry_index, timeout_ms, now_ms, input ready);
	modport sink (input valid, opcode, entry_index, timeout_ms, now_ms, output ready);
endinterface

/* design/ttt_out_if.sv */
// Result channel of the timeout timer table: valid/ready plus one result item.
// Depends on ttt_pkg for the field widths.
interface ttt_out_if import ttt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             expired;
	logic [IDX_W-1:0] expired_entry;
	logic [IVL_W-1:0] next_interval_ms;
	logic             last;

	modport source (output valid, expired, expired_entry, next_interval_ms, last, input ready);
	modport sink (input valid, expired, expired_entry, next_interval_ms, last, output ready);
endinterface

/* design/ttt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ttt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/ttt_eval.sv */
// Evaluation stage of the scan pipeline: classifies one table entry as expired,
// pending or neither and works out its remaining time. Depends on ttt_pkg.
module ttt_eval import ttt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              stall,
	input  s1_t               s1,
	input  logic [WORD_W-1:0] word,
	input  logic [NOW_W-1:0]  now,
	output s2_t               s2
);
	logic [DUR_W-1:0] dur;
	logic [NOW_W-1:0] dl;
	logic             after_now;

	assign dur       = word[WORD_W-1:NOW_W];
	assign dl        = word[NOW_W-1:0];
	assign after_now = dl > now;

	// A deadline of zero means the entry was armed with no timeout.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else if (!stall) begin
			s2.occ  <= s1.occ;
			s2.exp  <= s1.ev && (dl != '0) && !after_now;
			s2.pend <= s1.ev && after_now && (dur != '0);
			s2.idx  <= s1.idx;
			s2.rem  <= dl - now;
		end
	end
endmodule

/* design/ttt_ctrl.sv */
// Sequencer of the timeout timer table: command decode, valid marks, table
// writes, scan walk, interval tracking and the result register. Depends on ttt_pkg.
module ttt_ctrl import ttt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IVL_W-1:0]  cfg_wdata,
	ttt_in_if.sink            in_ch,
	ttt_out_if.source         out_ch,
	input  s2_t               s2,
	output s1_t               s1,
	output logic              stall,
	output logic [NOW_W-1:0]  now_q,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [WORD_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ACK  = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ENTRIES-1:0] valid_q;
	logic [IVL_W-1:0]   cfg_q;
	logic [IVL_W-1:0]   ivl_q;

	logic             out_valid_q;
	logic             out_exp_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [IVL_W-1:0] out_ivl_q;
	logic             out_last_q;

	logic             in_acc;
	logic             in_range;
	logic             out_free;
	logic             issue;
	logic             scan_done;
	logic             load_exp;
	logic             load_fin;
	logic             load_ack;
	logic             shorten;
	logic [NOW_W:0]   dl_sum;
	logic [NOW_W-1:0] dl_new;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_range    = int'(in_ch.entry_index) < ENTRIES;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign stall     = s2.occ && s2.exp && !out_free;
	assign issue     = (state_q == ST_SCAN) && (cnt_q != CNT_W'(ENTRIES)) && !stall;
	assign scan_done = (state_q == ST_SCAN) && (cnt_q == CNT_W'(ENTRIES)) && !s1.occ && !s2.occ;
	assign load_exp  = s2.occ && s2.exp && out_free;
	assign load_fin  = scan_done && out_free;
	assign load_ack  = (state_q == ST_ACK) && out_free;
	assign shorten   = s2.occ && !s2.exp && s2.pend && (NOW_W'(ivl_q) > s2.rem);

	// Deadline saturates at the top of the time range.
	assign dl_sum = {1'b0, in_ch.now_ms} + (NOW_W + 1)'(in_ch.timeout_ms);
	always_comb begin
		if (in_ch.timeout_ms == '0) begin
			dl_new = '0;
		end else if (dl_sum[NOW_W]) begin
			dl_new = '1;
		end else begin
			dl_new = dl_sum[NOW_W-1:0];
		end
	end

	assign ram_we    = in_acc && in_range && (in_ch.opcode == OP_ARM);
	assign ram_waddr = AW'(in_ch.entry_index);
	assign ram_wdata = {in_ch.timeout_ms, dl_new};
	assign ram_re    = issue;
	assign ram_raddr = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			valid_q     <= '0;
			cfg_q       <= CFG_RESET;
			out_valid_q <= 1'b0;
			s1          <= '0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (in_acc && in_range) begin
				if (in_ch.opcode == OP_ARM) begin
					valid_q[ram_waddr] <= 1'b1;
				end else if (in_ch.opcode == OP_REMOVE) begin
					valid_q[ram_waddr] <= 1'b0;
				end
			end
			if (!stall) begin
				s1.occ <= issue;
				s1.ev  <= valid_q[ram_raddr];
				s1.idx <= ram_raddr;
			end
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (load_exp || load_fin || load_ack) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.opcode == OP_SCAN) begin
							state_q <= ST_SCAN;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_ACK;
						end
					end
				end
				ST_SCAN: begin
					if (load_fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ACK: begin
					if (load_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_ch.opcode == OP_SCAN)) begin
			ivl_q <= cfg_q;
			now_q <= in_ch.now_ms;
		end else if (shorten) begin
			ivl_q <= sat_interval(s2.rem);
		end
		if (load_exp) begin
			out_exp_q  <= 1'b1;
			out_idx_q  <= IDX_W'(s2.idx);
			out_ivl_q  <= '0;
			out_last_q <= 1'b0;
		end else if (load_fin) begin
			out_exp_q  <= 1'b0;
			out_idx_q  <= '0;
			out_ivl_q  <= ivl_q;
			out_last_q <= 1'b1;
		end else if (load_ack) begin
			out_exp_q  <= 1'b0;
			out_idx_q  <= '0;
			out_ivl_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.expired          = out_exp_q;
	assign out_ch.expired_entry    = out_idx_q;
	assign out_ch.next_interval_ms = out_ivl_q;
	assign out_ch.last             = out_last_q;
endmodule

/* design/timeout_timer_table_top.sv */
// Timeout timer table: arm, remove and scan commands against a table of
// timeout entries. in_ch takes command items, out_ch returns result items,
// cfg_we/cfg_wdata write the default scan interval (reset value 60000 ms).
// Arm, remove and the unused opcode each return a single acknowledgement item
// with last set, passed through the ACK state into the result register.
// A scan reads the table one entry a cycle while out_ch does not stall, from
// a simple dual-port memory, and walks a two-stage pipeline (read, evaluate);
// it returns one item per expired entry and a final item with last set
// carrying the next interval. Each item is worked on alone, so in_ch.ready is
// low from acceptance until the item's final result is registered. When
// out_ch stalls with an expired item pending, the walk freezes in place and
// resumes without loss. Reset clears the valid marks and the control state at
// once; table contents are only used for valid entries, so no clearing pass is
// needed. Depends on ttt_pkg, the channel interfaces, ttt_ram, ttt_eval,
// ttt_ctrl and the assertion macro header.
`include "timeout_timer_table_top_macros.svh"

module timeout_timer_table_top import ttt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IVL_W-1:0] cfg_wdata,
	ttt_in_if.sink           in_ch,
	ttt_out_if.source        out_ch
);
	s1_t               s1;
	s2_t               s2;
	logic              stall;
	logic [NOW_W-1:0]  now_q;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	ttt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.s2        (s2),
		.s1        (s1),
		.stall     (stall),
		.now_q     (now_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	ttt_ram #(
		.WIDTH  (WORD_W),
		.DEPTH  (ENTRIES),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ttt_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.stall  (stall),
		.s1     (s1),
		.word   (ram_rdata),
		.now    (now_q),
		.s2     (s2)
	);

	// Table writes happen only while no scan is in flight.
	`TTT_ASSERT_SAME(a_no_write_during_scan, ram_we, !s1.occ && !s2.occ)
	// An accepted item keeps the input closed in the following cycle.
	`TTT_ASSERT_NEXT(a_one_item_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready)
	// No read is issued while the pipeline is frozen.
	`TTT_ASSERT_SAME(a_no_read_when_stalled, stall, !ram_re)
	// An evaluated entry is never both expired and pending.
	`TTT_ASSERT_SAME(a_exp_pend_exclusive, s2.occ, !(s2.exp && s2.pend))
endmodule
